/* rtl/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants
// Slot count, field widths, slot and operation codes, and the memory control
// word used by the open addressing hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

  // Table geometry (slot count must be a power of two, 8 to 65536)
  localparam int SLOTS    = 1024;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = IDX_W + 1;

  // Word field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int HASH_W   = 32;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 10;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = LIMIT_W'(768);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_TOMB  = 2'd1,
    KIND_LIVE  = 2'd2
  } kind_t;

  // One entry of the slot memory: kind and key side by side
  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  key;
  } slot_ent_t;

  // Write and read control for the slot and value memories
  typedef struct packed {
    logic kind_we;
    logic val_we;
    idx_t wr_addr;
    idx_t rd_addr;
  } mem_ctl_t;

endpackage

`default_nettype wire

/* rtl/oaht_if.sv */
// ----------------------------------------------------------------------------
// oaht_if: request and response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface oaht_req_if import oaht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [KEY_W-1:0]    key;
  logic [HASH_W-1:0]   key_hash;
  logic [VAL_W-1:0]    new_value;

  modport source (output valid, operation, key, key_hash, new_value, input ready);
  modport sink   (input valid, operation, key, key_hash, new_value, output ready);
endinterface

interface oaht_rsp_if import oaht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                was_new_key;
  logic [VAL_W-1:0]    found_value;

  modport source (output valid, status, was_new_key, found_value, input ready);
  modport sink   (input valid, status, was_new_key, found_value, output ready);
endinterface

`default_nettype wire

/* rtl/oaht_slot_ram.sv */
// ----------------------------------------------------------------------------
// oaht_slot_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oaht_slot_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/oaht_probe_ctrl.sv */
// ----------------------------------------------------------------------------
// oaht_probe_ctrl: probe sequencer
// Clears the slot memory after reset, walks the probe chain one slot per
// cycle, applies the update and holds the response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oaht_probe_ctrl import oaht_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  oaht_req_if.sink                in_req,
  oaht_rsp_if.source              out_rsp,
  input  wire logic [LIMIT_W-1:0] load_limit,
  output mem_ctl_t                mctl,
  output slot_ent_t               kind_wdata,
  output logic [VAL_W-1:0]        val_wdata,
  input  wire slot_ent_t          kind_rdata,
  input  wire logic [VAL_W-1:0]   val_rdata
);

  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_RESP
  } state_t;

  state_t             st_r, st_nxt;
  idx_t               idx_r, idx_nxt;
  idx_t               n_r, n_nxt;
  logic               has_tomb_r, has_tomb_nxt;
  idx_t               tomb_r, tomb_nxt;
  logic [CNT_W-1:0]   occ_cnt_r, occ_cnt_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               res_new_r, res_new_nxt;
  logic [VAL_W-1:0]   res_found_r, res_found_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_new_r, out_new_nxt;
  logic [VAL_W-1:0]   out_found_r, out_found_nxt;

  logic               is_empty, is_hit, is_tomb, is_last, done;
  logic               tomb_seen, room;
  idx_t               tomb_at;

  // Classify the slot just read
  always_comb begin
    is_empty  = (kind_rdata.kind == KIND_EMPTY);
    is_hit    = (kind_rdata.kind == KIND_LIVE) && (kind_rdata.key == key_r);
    is_tomb   = !is_empty && (kind_rdata.kind != KIND_LIVE);
    is_last   = (n_r == IDX_W'(SLOTS - 1));
    done      = is_empty || is_hit || is_last;
    tomb_seen = has_tomb_r || is_tomb;
    tomb_at   = has_tomb_r ? tomb_r : idx_r;
    room      = CMP_W'(occ_cnt_r) < CMP_W'(load_limit);
  end

  // Next state, memory control and result
  always_comb begin
    st_nxt         = st_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    has_tomb_nxt   = has_tomb_r;
    tomb_nxt       = tomb_r;
    occ_cnt_nxt    = occ_cnt_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_new_nxt    = res_new_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_new_nxt    = out_new_r;
    out_found_nxt  = out_found_r;

    mctl.kind_we    = 1'b0;
    mctl.val_we     = 1'b0;
    mctl.wr_addr    = idx_r;
    mctl.rd_addr    = idx_r + IDX_W'(1);
    kind_wdata.kind = KIND_LIVE;
    kind_wdata.key  = key_r;
    val_wdata       = val_r;

    case (st_r)
      // Sweep every slot to empty
      S_CLEAR: begin
        mctl.kind_we    = 1'b1;
        kind_wdata.kind = KIND_EMPTY;
        kind_wdata.key  = '0;
        idx_nxt         = idx_r + IDX_W'(1);
        if (&idx_r) begin
          st_nxt = S_IDLE;
        end
      end

      // Take a request word and start reading its home slot
      S_IDLE: begin
        mctl.rd_addr = in_req.key_hash[IDX_W-1:0];
        if (in_req.valid) begin
          op_nxt       = in_req.operation;
          key_nxt      = in_req.key;
          val_nxt      = in_req.new_value;
          idx_nxt      = in_req.key_hash[IDX_W-1:0];
          n_nxt        = '0;
          has_tomb_nxt = 1'b0;
          if (in_req.operation == OP_GET || in_req.operation == OP_SET ||
              in_req.operation == OP_DEL) begin
            st_nxt = S_PROBE;
          end else begin
            res_status_nxt = ST_MISSING;
            res_new_nxt    = 1'b0;
            res_found_nxt  = '0;
            st_nxt         = S_RESP;
          end
        end
      end

      // Inspect one slot per cycle; update memory when the chain ends
      S_PROBE: begin
        if (!done) begin
          idx_nxt      = idx_r + IDX_W'(1);
          n_nxt        = n_r + IDX_W'(1);
          has_tomb_nxt = tomb_seen;
          tomb_nxt     = tomb_at;
        end else begin
          st_nxt         = S_RESP;
          res_status_nxt = ST_MISSING;
          res_new_nxt    = 1'b0;
          res_found_nxt  = '0;
          case (op_r)
            OP_GET: begin
              if (is_hit) begin
                res_status_nxt = ST_OK;
                res_found_nxt  = val_rdata;
              end
            end
            OP_SET: begin
              if (is_hit) begin
                mctl.val_we    = 1'b1;
                res_status_nxt = ST_OK;
              end else if (tomb_seen) begin
                mctl.kind_we   = 1'b1;
                mctl.val_we    = 1'b1;
                mctl.wr_addr   = tomb_at;
                res_status_nxt = ST_OK;
                res_new_nxt    = 1'b1;
              end else if (is_empty && room) begin
                mctl.kind_we   = 1'b1;
                mctl.val_we    = 1'b1;
                occ_cnt_nxt    = occ_cnt_r + CNT_W'(1);
                res_status_nxt = ST_OK;
                res_new_nxt    = 1'b1;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            OP_DEL: begin
              if (is_hit) begin
                mctl.kind_we    = 1'b1;
                kind_wdata.kind = KIND_TOMB;
                res_status_nxt  = ST_OK;
              end
            end
            default: begin
              res_status_nxt = ST_MISSING;
            end
          endcase
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_new_nxt    = res_new_r;
          out_found_nxt  = res_found_r;
          st_nxt         = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    tomb_r       <= tomb_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_new_r    <= res_new_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_new_r    <= out_new_nxt;
    out_found_r  <= out_found_nxt;
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      idx_r       <= '0;
      has_tomb_r  <= 1'b0;
      occ_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      has_tomb_r  <= has_tomb_nxt;
      occ_cnt_r   <= occ_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_req.ready        = (st_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.was_new_key = out_new_r;
  assign out_rsp.found_value = out_found_r;

  // The count only moves by one, on a slot write at the end of a probe
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(occ_cnt_r) |-> ($past(mctl.kind_we) && ($past(st_r) == S_PROBE) &&
                             (occ_cnt_r == $past(occ_cnt_r) + CNT_W'(1))))
    else $error("occupied count moved outside a fresh-slot set");

  // An accepted word always starts a probe or goes straight to response
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (st_r == S_PROBE || st_r == S_RESP))
    else $error("accepted word did not start processing");

  // Value writes come only from a set that finishes its probe
  a_val_wr: assert property (@(posedge clk) disable iff (!rst_n)
    mctl.val_we |-> (st_r == S_PROBE && op_r == OP_SET && done))
    else $error("value memory written outside a set");

  // A new response word is only loaded from the response state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(st_r) == S_RESP))
    else $error("response word raised without a finished request");

endmodule

`default_nettype wire

/* rtl/open_addressing_hash_table_core.sv */
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core: linear probing hash table with tombstones
// Get, set and delete on a table of SLOTS (1024) slots mapping 32-bit keys to
// 64-bit values. Probing starts at key_hash AND (SLOTS-1) and visits one slot
// per cycle, reading kind, key and value from two registered-read memories at
// the same address. A request is accepted in the idle state, which issues the
// first read, then visits P slots (1 to SLOTS; none for an unknown operation
// code) and hands over the response from the response state. One request is
// in flight at a time, and the next word is taken while a finished response
// still waits in the output register. After reset the slot memory is swept to
// empty, during which no request word is accepted; load_limit writes are taken
// at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module open_addressing_hash_table_core import oaht_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  oaht_req_if.sink                in_req,
  oaht_rsp_if.source              out_rsp,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  logic [LIMIT_W-1:0] load_limit_r;
  mem_ctl_t           mctl;
  slot_ent_t          kind_wdata;
  slot_ent_t          kind_rdata;
  logic [VAL_W-1:0]   val_wdata;
  logic [VAL_W-1:0]   val_rdata;

  // Load limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_limit_r <= LOAD_LIMIT_RST;
    end else if (cfg_we) begin
      load_limit_r <= cfg_wdata;
    end
  end

  // Probe sequencer
  oaht_probe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_rsp    (out_rsp),
    .load_limit (load_limit_r),
    .mctl       (mctl),
    .kind_wdata (kind_wdata),
    .val_wdata  (val_wdata),
    .kind_rdata (kind_rdata),
    .val_rdata  (val_rdata)
  );

  // Slot kind and key memory
  oaht_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH ($bits(slot_ent_t))
  ) u_kind_ram (
    .clk   (clk),
    .we    (mctl.kind_we),
    .waddr (mctl.wr_addr),
    .wdata (kind_wdata),
    .raddr (mctl.rd_addr),
    .rdata (kind_rdata)
  );

  // Slot value memory
  oaht_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (VAL_W)
  ) u_val_ram (
    .clk   (clk),
    .we    (mctl.val_we),
    .waddr (mctl.wr_addr),
    .wdata (val_wdata),
    .raddr (mctl.rd_addr),
    .rdata (val_rdata)
  );

endmodule

`default_nettype wire
